### rtl/msr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the masked signature scan and resolve unit.
// No dependencies; every other file in this block but msr_stream_if imports this package.
package msr_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int PATTERN_BYTES     = 16;
  localparam int DISP_BYTES        = 4;
  localparam int DISP_W            = 32;
  localparam int ADDR_W            = 64;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int CARE_W            = 16;
  localparam int LEN_W             = 5;
  localparam int OFFSET_W          = 8;
  localparam int GOT_W             = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_BASE_ADDRESS = 3'd4,
    REG_DISP_OFFSET  = 3'd5,
    REG_INSTR_LENGTH = 3'd6
  } cfg_reg_t;

  // Outcome of the window compare for the current byte.
  typedef struct packed {
    logic              hit;
    logic [GOT_W-1:0]  got;
    logic [DISP_W-1:0] disp;
  } msr_match_t;

endpackage

### rtl/msr_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte stream and the scan result.
// Depends on nothing; used by the top level of the scan unit.
interface msr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msr_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] match_address;
  logic        resolved;
  logic [63:0] target_address;

  modport source (output valid, output found, output match_address,
                  output resolved, output target_address, input ready);
  modport sink   (input valid, input found, input match_address,
                  input resolved, input target_address, output ready);
endinterface

### rtl/msr_match.sv
`timescale 1ns / 1ps
// Masked window compare and gathering of displacement bytes already in the window.
// Depends on msr_pkg.
module msr_match #(
  parameter int  PATTERN_MAX = msr_pkg::PATTERN_MAX_DEF,
  localparam int NCMP = (PATTERN_MAX < msr_pkg::PATTERN_BYTES) ?
                        PATTERN_MAX : msr_pkg::PATTERN_BYTES
) (
  input  logic [NCMP-1:0][7:0]                      window,
  input  logic [msr_pkg::PATTERN_BYTES-1:0][7:0]    pattern,
  input  logic [msr_pkg::CARE_W-1:0]                care_mask,
  input  logic [msr_pkg::LEN_W-1:0]                 pattern_length,
  input  logic [msr_pkg::OFFSET_W-1:0]              disp_offset,
  input  logic                                      enable,
  output msr_pkg::msr_match_t                       result
);
  import msr_pkg::*;

  localparam int IDXW = (NCMP > 1) ? $clog2(NCMP) : 1;
  localparam int LW   = 7;
  localparam int SW   = 9;

  logic          len_ok;
  logic          all_ok;
  logic [LW-1:0] cmp_idx  [NCMP];
  logic [SW-1:0] span;
  logic [SW-1:0] disp_idx [DISP_BYTES];
  logic [GOT_W-1:0] got;
  logic [DISP_W-1:0] disp;

  assign len_ok = (pattern_length != '0) && (LW'(pattern_length) <= LW'(NCMP));

  // Pattern byte j lines up with the window entry length-1-j (newest first).
  always_comb begin
    all_ok = 1'b1;
    for (int j = 0; j < NCMP; j++) begin
      cmp_idx[j] = LW'(pattern_length) - LW'(j) - LW'(1);
      if ((LW'(j) < LW'(pattern_length)) && care_mask[j] &&
          (pattern[j] != window[cmp_idx[j][IDXW-1:0]])) begin
        all_ok = 1'b0;
      end
    end
  end

  // Displacement bytes that already sit in the window at match time.
  always_comb begin
    if (SW'(pattern_length) > SW'(disp_offset)) begin
      span = SW'(pattern_length) - SW'(disp_offset);
    end else begin
      span = '0;
    end
    got = (span >= SW'(DISP_BYTES)) ? GOT_W'(DISP_BYTES) : span[GOT_W-1:0];
    disp = '0;
    for (int k = 0; k < DISP_BYTES; k++) begin
      disp_idx[k] = SW'(pattern_length) - SW'(disp_offset) - SW'(k) - SW'(1);
      if (GOT_W'(k) < got) begin
        disp[k*8 +: 8] = window[disp_idx[k][IDXW-1:0]];
      end
    end
  end

  assign result.hit  = enable && len_ok && all_ok;
  assign result.got  = got;
  assign result.disp = disp;

endmodule

### rtl/masked_signature_scan_resolve_unit.sv
`timescale 1ns / 1ps
// Top level of the masked signature scan and resolve unit.
// Depends on msr_pkg, msr_stream_if (msr_in_if, msr_out_if) and msr_match.
//
//   Channel   Role     Transaction payload
//   -------   ------   ------------------------------------------------------
//   stream    sink     data_byte[7:0], last_byte
//   result    source   found, match_address[63:0], resolved, target_address[63:0]
//   cfg_*     write    cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// One stream byte is taken per cycle unless the stream stalls; the compare and
// the displacement capture finish in the cycle the byte arrives.
// A byte marked last leaves its result through the final-state snapshot
// register and then the output register, where the two 64-bit address sums
// are formed.
// Synchronous active-high reset clears configuration and stream control flags.
// The stream stalls only while a snapshot is held and a full output is not taken.
module masked_signature_scan_resolve_unit #(
  parameter int PATTERN_MAX   = msr_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = msr_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]    cfg_data,
  msr_in_if.sink                            stream,
  msr_out_if.source                         result
);
  import msr_pkg::*;

  // Only the first sixteen window entries can ever be compared or read back,
  // so the window is no deeper than the pattern registers allow.
  localparam int NCMP = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
  localparam int PB   = POSITION_BITS;
  localparam int XW   = PB + 2;

  // Configuration registers.
  logic [63:0]         pattern_low;
  logic [63:0]         pattern_high;
  logic [CARE_W-1:0]   care_mask;
  logic [LEN_W-1:0]    pattern_length;
  logic [ADDR_W-1:0]   base_address;
  logic [OFFSET_W-1:0] disp_offset;
  logic [OFFSET_W-1:0] instr_length;

  // Stream state.
  logic [NCMP-1:0][7:0] window;
  logic [NCMP-1:0][7:0] window_next;
  logic [PB-1:0]        byte_pos;
  logic                 match_seen;
  logic                 match_seen_next;
  logic [PB-1:0]        match_pos;
  logic [PB-1:0]        match_pos_next;
  logic [DISP_W-1:0]    disp;
  logic [DISP_W-1:0]    disp_next;
  logic [GOT_W-1:0]     got;
  logic [GOT_W-1:0]     got_next;
  logic [XW-1:0]        next_idx;
  logic [XW-1:0]        next_idx_next;

  // Final-state snapshot between the scan and the address adders.
  logic              snap_valid;
  logic              snap_found;
  logic              snap_resolved;
  logic [PB-1:0]     snap_pos;
  logic [DISP_W-1:0] snap_disp;

  // Output register.
  logic              out_valid;
  logic              out_found;
  logic              out_resolved;
  logic [ADDR_W-1:0] out_match_address;
  logic [ADDR_W-1:0] out_target_address;

  logic accept;
  logic step;
  logic snap_move;
  logic len_reached;
  logic capture;
  logic [9:0] idx_delta;
  logic [ADDR_W-1:0] sum_match;
  logic [ADDR_W-1:0] sum_target;
  logic [PATTERN_BYTES-1:0][7:0] pattern;
  msr_match_t m;

  assign pattern = {pattern_high, pattern_low};

  // The snapshot can move on when the output register is empty or draining.
  assign snap_move    = snap_valid && (!out_valid || result.ready);
  assign stream.ready = !snap_valid || snap_move;
  assign accept       = stream.valid && stream.ready;
  // Once the position counter saturates, further bytes are ignored.
  assign step         = accept && (byte_pos != '1);

  always_comb begin
    window_next[0] = stream.data_byte;
    for (int i = 1; i < NCMP; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign len_reached = ((PB+1)'(byte_pos) + (PB+1)'(1)) >= (PB+1)'(pattern_length);

  msr_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .window         (window_next),
    .pattern        (pattern),
    .care_mask      (care_mask),
    .pattern_length (pattern_length),
    .disp_offset    (disp_offset),
    .enable         (!match_seen && len_reached),
    .result         (m)
  );

  // A byte that arrives exactly at the next displacement position is captured
  // live; bytes that were already in the window come from the compare unit.
  assign capture = match_seen && (got < GOT_W'(DISP_BYTES)) &&
                   (next_idx == XW'(byte_pos));

  // Offset from the current position to the first byte still to be captured.
  assign idx_delta = 10'd1 + 10'(disp_offset) + 10'(m.got) - 10'(pattern_length);

  always_comb begin
    match_seen_next = match_seen;
    match_pos_next  = match_pos;
    disp_next       = disp;
    got_next        = got;
    next_idx_next   = next_idx;
    if (step) begin
      if (capture) begin
        for (int k = 0; k < DISP_BYTES; k++) begin
          if (got == GOT_W'(k)) begin
            disp_next[k*8 +: 8] = stream.data_byte;
          end
        end
        got_next      = got + GOT_W'(1);
        next_idx_next = next_idx + XW'(1);
      end else if (m.hit) begin
        match_seen_next = 1'b1;
        match_pos_next  = byte_pos + PB'(1) - PB'(pattern_length);
        disp_next       = m.disp;
        got_next        = m.got;
        next_idx_next   = XW'(byte_pos) + XW'(signed'(idx_delta));
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
      base_address   <= '0;
      disp_offset    <= '0;
      instr_length   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_CARE_MASK:    care_mask      <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        REG_BASE_ADDRESS: base_address   <= cfg_data;
        REG_DISP_OFFSET:  disp_offset    <= cfg_data[OFFSET_W-1:0];
        REG_INSTR_LENGTH: instr_length   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Stream state: the window and displacement bytes need no reset because
  // they are only read at positions that were written in the current stream.
  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
    match_pos <= match_pos_next;
    disp      <= disp_next;
    next_idx  <= next_idx_next;
    if (rst) begin
      byte_pos   <= '0;
      match_seen <= 1'b0;
      got        <= '0;
    end else if (accept && stream.last_byte) begin
      byte_pos   <= '0;
      match_seen <= 1'b0;
      got        <= '0;
    end else begin
      if (step) begin
        byte_pos <= byte_pos + PB'(1);
      end
      match_seen <= match_seen_next;
      got        <= got_next;
    end
  end

  // Snapshot of the state left by the last byte of a stream.
  always_ff @(posedge clk) begin
    if (accept && stream.last_byte) begin
      snap_found    <= match_seen_next;
      snap_resolved <= (got_next == GOT_W'(DISP_BYTES));
      snap_pos      <= match_pos_next;
      snap_disp     <= disp_next;
    end
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && stream.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  assign sum_match  = base_address + ADDR_W'(snap_pos);
  assign sum_target = sum_match + ADDR_W'(instr_length) + ADDR_W'(signed'(snap_disp));

  // Output register.
  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_found          <= snap_found;
      out_resolved       <= snap_found && snap_resolved;
      out_match_address  <= snap_found ? sum_match : '0;
      out_target_address <= (snap_found && snap_resolved) ? sum_target : '0;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid          = out_valid;
  assign result.found          = out_found;
  assign result.match_address  = out_match_address;
  assign result.resolved       = out_resolved;
  assign result.target_address = out_target_address;

endmodule

### tb/sv/tb_masked_signature_scan_resolve_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for masked_signature_scan_resolve_unit: a directed table, then random
// streams over several register settings, checked against the table and an in-bench scan predictor.
// Depends on msr_pkg, msr_stream_if (msr_in_if, msr_out_if) and the unit itself.
module tb_masked_signature_scan_resolve_unit;
  import msr_pkg::*;

  localparam int WINDOW = PATTERN_MAX_DEF;
  localparam logic [63:0] POSITION_CAP = (64'd1 << POSITION_BITS_DEF) - 64'd1;
  // Index 7 maps to no register; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 36;
  localparam int PRESSURE_CYCLES = 200;
  // The longest correct stretch without any transaction is the pressure hold-off; random gaps
  // and stalls are geometric and far shorter.
  localparam int QUIET_LIMIT = 2000;
  // Spare cycles after the last expected result has arrived, before the next write.
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
    logic        resolved;
    logic [63:0] target_address;
  } scan_result_t;

  localparam scan_result_t NO_MATCH = '0;

  // One row of the directed table: either a register write or one stream byte.
  typedef struct packed {
    bit                     is_write;
    logic [CFG_INDEX_W-1:0] index;
    logic [63:0]            value;
    logic [7:0]             data;
    logic                   lst;
    bit                     typed;
    scan_result_t           want;
  } step_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  msr_in_if  in_ch ();
  msr_out_if out_ch ();

  masked_signature_scan_resolve_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .stream   (in_ch),
    .result   (out_ch)
  );

  // Shadow copy of the configuration registers, updated as each write lands.
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [15:0] care_q   = '0;
  logic [4:0]  len_q    = '0;
  logic [63:0] base_q   = '0;
  logic [7:0]  doff_q   = '0;
  logic [7:0]  ilen_q   = '0;

  // Predictor stream state: newest byte in window_q[0].
  logic [7:0]  window_q [WINDOW];
  logic [63:0] pos_q;
  bit          seen_q;
  logic [63:0] mpos_q;
  logic [31:0] disp_q;
  int          got_q;

  scan_result_t expected_scans[$];
  step_row_t    directed_rows[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  scans_checked = 0;
  int  found_count = 0;
  int  resolved_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  pressure_req = 0;
  int  quiet_cycles = 0;

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pattern_byte_at(int j);
    return (j < 8) ? pat_lo_q[j*8 +: 8] : pat_hi_q[(j-8)*8 +: 8];
  endfunction

  function automatic void clear_scan();
    foreach (window_q[i]) window_q[i] = '0;
    pos_q  = '0;
    seen_q = 1'b0;
    mpos_q = '0;
    disp_q = '0;
    got_q  = 0;
  endfunction

  function automatic void take_disp(logic [7:0] b);
    disp_q[got_q*8 +: 8] = b;
    got_q++;
  endfunction

  // Advances the predicted scan state by one accepted byte. On a last byte it
  // gives the expected result and clears the stream state.
  function automatic void scan_byte(input logic [7:0] b, input logic is_last,
                                    output bit emits, output scan_result_t res);
    bit          ok;
    int          plen;
    logic [63:0] idx;
    logic [63:0] maddr;
    emits = 1'b0;
    res   = NO_MATCH;
    plen  = int'(len_q);
    // Once the position counter saturates, bytes are neither scanned nor captured.
    if (pos_q < POSITION_CAP) begin
      for (int i = WINDOW - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = b;
      // Displacement bytes that lie after the match are caught as they arrive.
      if (seen_q && got_q < 4 && mpos_q + doff_q + got_q == pos_q) take_disp(b);
      // A zero or oversized length never matches; neither does a short stream.
      if (!seen_q && plen != 0 && plen <= 16 && plen <= WINDOW && pos_q + 1 >= plen) begin
        ok = 1'b1;
        for (int j = 0; j < plen; j++) begin
          if (care_q[j] && pattern_byte_at(j) != window_q[plen-1-j]) ok = 1'b0;
        end
        if (ok) begin
          seen_q = 1'b1;
          mpos_q = pos_q + 1 - plen;
          // Displacement bytes already in the window are taken from it at once.
          while (got_q < 4) begin
            idx = mpos_q + doff_q + got_q;
            if (idx > pos_q || pos_q - idx >= WINDOW) break;
            take_disp(window_q[pos_q - idx]);
          end
        end
      end
      pos_q = pos_q + 1;
    end
    if (is_last) begin
      emits = 1'b1;
      if (seen_q) begin
        maddr = base_q + mpos_q;
        res.found = 1'b1;
        res.match_address = maddr;
        // A displacement that ran past the end leaves the target unresolved.
        if (got_q >= 4) begin
          res.resolved = 1'b1;
          res.target_address = maddr + ilen_q + {{32{disp_q[31]}}, disp_q};
        end
      end
      clear_scan();
    end
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Register writes happen only while the unit is idle, so the shadow copy can
  // take the new value right at the write edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  pat_lo_q = value;
      REG_PATTERN_HIGH: pat_hi_q = value;
      REG_CARE_MASK:    care_q   = value[15:0];
      REG_PATTERN_LEN:  len_q    = value[4:0];
      REG_BASE_ADDRESS: base_q   = value;
      REG_DISP_OFFSET:  doff_q   = value[7:0];
      REG_INSTR_LENGTH: ilen_q   = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stops offering bytes and waits until every expected result has arrived,
  // then lets the output pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one byte after a random idle gap and waits for the transaction.
  // The predictor runs on acceptance; typed rows push their own expectation.
  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit typed,
                           input scan_result_t want);
    bit           emits;
    scan_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    bytes_sent++;
    scan_byte(b, is_last, emits, res);
    if (emits) expected_scans.push_back(typed ? want : res);
  endtask

  function automatic void add_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    step_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.index = idx;
    r.value = value;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] data, logic lst, bit typed, scan_result_t want);
    step_row_t r;
    r = '0;
    r.data = data;
    r.lst = lst;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  // Result receiver: random stalls per phase, plus one long hold-off on request
  // so that the output stage fills and the stream input has to stall.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        hold_left = PRESSURE_CYCLES;
        pressure_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker and watchdog. Each accepted result transaction is compared
  // field by field against the oldest expectation.
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_scans.size() == 0) begin
          report("result with nothing expected, found", 64'(out_ch.found), '0);
        end else begin
          want = expected_scans.pop_front();
          scans_checked++;
          if (want.found) found_count++;
          if (want.resolved) resolved_count++;
          if (out_ch.found !== want.found)
            report("found", 64'(out_ch.found), 64'(want.found));
          if (out_ch.match_address !== want.match_address)
            report("match_address", out_ch.match_address, want.match_address);
          if (out_ch.resolved !== want.resolved)
            report("resolved", 64'(out_ch.resolved), 64'(want.resolved));
          if (out_ch.target_address !== want.target_address)
            report("target_address", out_ch.target_address, want.target_address);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected_scans.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then random streams over several settings.
  initial begin
    step_row_t   row;
    bit          in_flight;
    logic [63:0] cfg_vals [7];
    logic [7:0]  stream_q[$];
    int          n;
    int          plen;
    int          eff;
    int          need;
    int          sel;
    int          slen;
    int          start;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_flight = 1'b0;
    clear_scan();

    // Zero pattern length right after reset: never a match, even on a one-byte stream.
    add_byte(8'h00, 1'b1, 1'b1, NO_MATCH);
    add_byte(8'hFF, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h5A, 1'b1, 1'b1, NO_MATCH);
    // Three-byte opcode pattern with a 4-byte displacement right behind it.
    add_write(REG_PATTERN_LOW, 64'h0000_0000_0005_8B48);
    add_write(REG_CARE_MASK, 64'h0000_0000_0000_0007);
    add_write(REG_PATTERN_LEN, 64'd3);
    add_write(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFF0);
    add_write(REG_DISP_OFFSET, 64'd3);
    add_write(REG_INSTR_LENGTH, 64'd7);
    // Negative displacement, and the target wraps around the top of the address space.
    add_byte(8'h48, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h8B, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h05, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h10, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h00, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h00, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h80, 1'b1, 1'b1, {1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 64'hFFFF_FFFF_8000_0007});
    // Stream shorter than the pattern.
    add_byte(8'h48, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h8B, 1'b1, 1'b1, NO_MATCH);
    // Match found, but the displacement runs past the last byte.
    add_byte(8'h48, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h8B, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h05, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h01, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h02, 1'b1, 1'b1, {1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 64'h0});
    // Oversized lengths never match.
    add_write(REG_PATTERN_LEN, 64'd17);
    add_byte(8'h48, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h8B, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'h05, 1'b1, 1'b1, NO_MATCH);
    add_write(REG_PATTERN_LEN, 64'd31);
    add_byte(8'h48, 1'b1, 1'b1, NO_MATCH);
    // All wildcards: match at the start, displacement read back from the window,
    // -1 plus the largest instruction length. The write to the unmapped index
    // comes last so that any aliasing into a real register would show.
    add_write(REG_PATTERN_LEN, 64'd4);
    add_write(REG_CARE_MASK, 64'd0);
    add_write(REG_BASE_ADDRESS, 64'd0);
    add_write(REG_DISP_OFFSET, 64'd0);
    add_write(REG_INSTR_LENGTH, 64'd255);
    add_write(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_byte(8'hFF, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'hFF, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'hFF, 1'b0, 1'b0, NO_MATCH);
    add_byte(8'hFF, 1'b1, 1'b1, {1'b1, 64'h0, 1'b1, 64'h0000_0000_0000_00FE});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_write) begin
        if (in_flight) drain();
        in_flight = 1'b0;
        write_reg(row.index, row.value);
      end else begin
        send_byte(row.data, row.lst, row.typed, row.want);
        in_flight = 1'b1;
      end
    end
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      // Random settings by default; some phases pin the extremes.
      cfg_vals[REG_PATTERN_LOW]  = rand64();
      cfg_vals[REG_PATTERN_HIGH] = rand64();
      cfg_vals[REG_CARE_MASK]    = 64'($urandom_range(0, 16'hFFFF));
      cfg_vals[REG_PATTERN_LEN]  = 64'($urandom_range(1, 16));
      cfg_vals[REG_BASE_ADDRESS] = rand64();
      cfg_vals[REG_DISP_OFFSET]  = 64'($urandom_range(0, 12));
      cfg_vals[REG_INSTR_LENGTH] = 64'($urandom_range(0, 255));
      case (phase)
        0: begin
          cfg_vals[REG_PATTERN_LEN]  = 64'd16;
          cfg_vals[REG_CARE_MASK]    = 64'hFFFF;
          cfg_vals[REG_BASE_ADDRESS] = 64'hFFFF_FFFF_FFFF_FFFF;
          cfg_vals[REG_DISP_OFFSET]  = 64'd0;
          cfg_vals[REG_INSTR_LENGTH] = 64'd255;
        end
        2: begin
          // Largest displacement offset: one long stream is enough here.
          cfg_vals[REG_PATTERN_LEN]  = 64'd1;
          cfg_vals[REG_CARE_MASK]    = 64'h0001;
          cfg_vals[REG_BASE_ADDRESS] = 64'd0;
          cfg_vals[REG_DISP_OFFSET]  = 64'd255;
          cfg_vals[REG_INSTR_LENGTH] = 64'd0;
        end
        3: cfg_vals[REG_PATTERN_LEN] = 64'd0;
        4: begin
          // Short streams, so the long receiver hold-off backs results up.
          cfg_vals[REG_PATTERN_LEN] = 64'd2;
          cfg_vals[REG_CARE_MASK]   = 64'h0003;
          cfg_vals[REG_DISP_OFFSET] = 64'd0;
        end
        5: cfg_vals[REG_PATTERN_LEN] = 64'd20;
        6: cfg_vals[REG_CARE_MASK] = 64'h0000;
        default: ;
      endcase
      // Bits above the width of the narrow registers are random and must be dropped.
      cfg_vals[REG_CARE_MASK]    = (rand64() << 16) | {48'd0, cfg_vals[REG_CARE_MASK][15:0]};
      cfg_vals[REG_PATTERN_LEN]  = (rand64() << 5) | {59'd0, cfg_vals[REG_PATTERN_LEN][4:0]};
      cfg_vals[REG_DISP_OFFSET]  = (rand64() << 8) | {56'd0, cfg_vals[REG_DISP_OFFSET][7:0]};
      cfg_vals[REG_INSTR_LENGTH] = (rand64() << 8) | {56'd0, cfg_vals[REG_INSTR_LENGTH][7:0]};
      for (int r = 0; r < 7; r++) write_reg(3'(r), cfg_vals[r]);

      // Idling: none, sender only, receiver only, then both.
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (phase == 4) pressure_req = 1'b1;

      n = 0;
      while (n < PHASE_ITEMS) begin
        // Mostly streams long enough to hold the pattern and its displacement,
        // some that end before the displacement, some shorter than the pattern.
        plen = int'(len_q);
        eff  = (plen >= 1 && plen <= 16) ? plen : 1;
        need = eff + int'(doff_q) + 4;
        sel  = $urandom_range(0, 9);
        if (sel == 0) slen = $urandom_range(1, eff);
        else if (sel == 1) slen = $urandom_range(eff, need - 1);
        else slen = need + $urandom_range(0, 10);
        stream_q.delete();
        repeat (slen) stream_q.push_back(8'($urandom_range(0, 255)));
        // Plant the pattern in most streams; wildcard positions keep random bytes.
        if (plen >= 1 && plen <= 16 && slen >= plen && $urandom_range(0, 3) != 0) begin
          start = (slen >= need) ? $urandom_range(0, slen - need)
                                 : $urandom_range(0, slen - plen);
          for (int j = 0; j < plen; j++) begin
            if (care_q[j]) stream_q[start + j] = pattern_byte_at(j);
          end
        end
        foreach (stream_q[k]) send_byte(stream_q[k], k == stream_q.size() - 1, 1'b0, NO_MATCH);
        n += slen;
      end
      drain();
    end

    $display("covered %0d stream bytes under %0d register settings, incl. a long receiver hold-off",
             bytes_sent, PHASES + 1);
    $display("checked %0d scan results: %0d with a match, %0d with a resolved target",
             scans_checked, found_count, resolved_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
